@@ hdl/tkf_pkg.sv @@
// ----------------------------------------------------------------------------
// tkf_pkg
// Shared types, reset values, CORDIC angle table and saturation helpers for
// the tilt Kalman filter.
// ----------------------------------------------------------------------------
`default_nettype none

package tkf_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int TAB_N            = 24;

  localparam logic [15:0]        TIME_STEP_RST = 16'd66;
  localparam logic [30:0]        APN_RST       = 31'd66;
  localparam logic [30:0]        BPN_RST       = 31'd197;
  localparam logic [30:0]        MN_RST        = 31'd19661;
  localparam logic signed [31:0] COV_ONE       = 32'sd65536;

  typedef enum logic [1:0] {
    REG_TIME_STEP   = 2'd0,
    REG_ANGLE_NOISE = 2'd1,
    REG_BIAS_NOISE  = 2'd2,
    REG_MEAS_NOISE  = 2'd3
  } cfg_reg_t;

  typedef enum logic [6:0] {
    S_IDLE        = 7'b0000001,
    S_MUL_A       = 7'b0000010,
    S_MUL_B       = 7'b0000100,
    S_WAIT_CORDIC = 7'b0001000,
    S_DIV_START   = 7'b0010000,
    S_DIV_WAIT    = 7'b0100000,
    S_OUT         = 7'b1000000
  } seq_state_t;

  typedef enum logic [3:0] {
    OP_ANGLE_PRED = 4'd0,
    OP_AA_PRED    = 4'd1,
    OP_AB_PRED    = 4'd2,
    OP_BB_PRED    = 4'd3,
    OP_BA_CORR    = 4'd4,
    OP_BB_CORR    = 4'd5,
    OP_AA_CORR    = 4'd6,
    OP_AB_CORR    = 4'd7,
    OP_ANGLE_CORR = 4'd8,
    OP_BIAS_CORR  = 4'd9
  } mul_op_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] value;
  } unit_res_t;

  // 57.295 * atan(2^-i) degrees, Q30
  function automatic logic [39:0] atan_entry(input logic [4:0] idx);
    logic [39:0] v;
    begin
      case (idx)
        5'd0:  v = 40'd48317724705;
        5'd1:  v = 40'd28523618434;
        5'd2:  v = 40'd15071096617;
        5'd3:  v = 40'd7650323966;
        5'd4:  v = 40'd3840007551;
        5'd5:  v = 40'd1921875734;
        5'd6:  v = 40'd961172375;
        5'd7:  v = 40'd480615517;
        5'd8:  v = 40'd240311425;
        5'd9:  v = 40'd120156171;
        5'd10: v = 40'd60078143;
        5'd11: v = 40'd30039079;
        5'd12: v = 40'd15019540;
        5'd13: v = 40'd7509770;
        5'd14: v = 40'd3754885;
        5'd15: v = 40'd1877443;
        5'd16: v = 40'd938721;
        5'd17: v = 40'd469361;
        5'd18: v = 40'd234680;
        5'd19: v = 40'd117340;
        5'd20: v = 40'd58670;
        5'd21: v = 40'd29335;
        5'd22: v = 40'd14668;
        5'd23: v = 40'd7334;
        default: v = 40'd0;
      endcase
      return v;
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    begin
      if (v > 66'sd2147483647)       r = 32'sh7fffffff;
      else if (v < -66'sd2147483648) r = 32'sh80000000;
      else                           r = v[31:0];
      return r;
    end
  endfunction

  function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [65:0] s;
    begin
      s = 66'(a) + 66'(b);
      return sat32(s);
    end
  endfunction

  function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [65:0] s;
    begin
      s = 66'(a) - 66'(b);
      return sat32(s);
    end
  endfunction

endpackage

`default_nettype wire

@@ hdl/tilt_kalman_filter_core.sv @@
// ----------------------------------------------------------------------------
// tilt_kalman_filter_core
// Two-state (angle, gyro bias) Kalman tilt filter on one shared multiplier.
//
// Input words on in_*: gyro rate, accel X and accel Z. One result word per
// input on out_*: filtered angle, unbiased rate, corrected bias (Q16.16).
// Registers are written on cfg_* (always ready); the user must write them
// only while the block is idle, which the block itself does not enforce.
// A word passes ten multiply steps, each a load and an accumulate phase,
// on the shared 32x32 multiplier, a CORDIC of CORDIC_STEPS iterations
// overlapped with prediction, and two bit-serial divisions. in_tready is
// high only between words: no new word is taken until the last is loaded out.
// The result sits in an output register; the next word is taken while it
// waits, and the sequencer holds at its end if the receiver still stalls.
// Synchronous reset loads the register defaults, zero angle and bias and
// unit covariance diagonal; no word is pending after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module tilt_kalman_filter_core #(
  parameter int CORDIC_STEPS = tkf_pkg::CORDIC_STEPS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [63:0] in_tdata,   // gyro_rate[31:0], accel_x[47:32], accel_z[63:48]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [95:0] out_tdata,  // tilt_angle[31:0], unbiased_rate[63:32], bias_estimate[95:64]
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [31:0] cfg_data
);

  tkf_pkg::seq_state_t state_r, state_nxt;
  tkf_pkg::mul_op_t    op_r, op_nxt;

  logic [15:0] ts_r;
  logic [30:0] apn_r;
  logic [30:0] bpn_r;
  logic [30:0] mn_r;

  logic signed [31:0] angle_r, bias_r, caa_r, cab_r, cba_r, cbb_r;
  logic signed [31:0] q_r, err_r, k0_r, k1_r;
  logic signed [32:0] e_r;
  logic signed [63:0] prod_r;
  logic               div_sel_r;

  logic               out_valid_r;
  logic signed [31:0] out_angle_r, out_rate_r, out_bias_r;

  logic               accept;
  logic               div_start;
  logic               out_load;
  logic signed [31:0] opa, opb;
  logic signed [33:0] pd0_w;
  logic signed [31:0] dt_s;
  logic signed [63:0] rnd_w;
  logic signed [31:0] r;

  tkf_pkg::unit_res_t cordic_res;
  tkf_pkg::unit_res_t div_res;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == tkf_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign div_start = (state_r == tkf_pkg::S_DIV_START);
  assign out_load  = (state_r == tkf_pkg::S_OUT) && (!out_valid_r || out_tready);

  tkf_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (accept),
    .accel_x ($signed(in_tdata[47:32])),
    .accel_z ($signed(in_tdata[63:48])),
    .res     (cordic_res)
  );

  tkf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_sel_r ? cba_r : caa_r),
    .den   (e_r),
    .res   (div_res)
  );

  always_comb begin
    dt_s  = $signed({16'b0, ts_r});
    pd0_w = $signed({3'b0, apn_r}) - 34'(cab_r) - 34'(cba_r);
    case (op_r)
      tkf_pkg::OP_ANGLE_PRED: begin opa = q_r; opb = dt_s; end
      tkf_pkg::OP_AA_PRED:    begin opa = tkf_pkg::sat32(66'(pd0_w)); opb = dt_s; end
      tkf_pkg::OP_AB_PRED:    begin opa = tkf_pkg::sat32(-(66'(cbb_r))); opb = dt_s; end
      tkf_pkg::OP_BB_PRED:    begin opa = $signed({1'b0, bpn_r}); opb = dt_s; end
      tkf_pkg::OP_BA_CORR:    begin opa = k1_r; opb = caa_r; end
      tkf_pkg::OP_BB_CORR:    begin opa = k1_r; opb = cab_r; end
      tkf_pkg::OP_AA_CORR:    begin opa = k0_r; opb = caa_r; end
      tkf_pkg::OP_AB_CORR:    begin opa = k0_r; opb = cab_r; end
      tkf_pkg::OP_ANGLE_CORR: begin opa = k0_r; opb = err_r; end
      tkf_pkg::OP_BIAS_CORR:  begin opa = k1_r; opb = err_r; end
      default:                begin opa = 32'sd0; opb = 32'sd0; end
    endcase
    rnd_w = (prod_r + 64'sd32768) >>> 16;
    r     = tkf_pkg::sat32(66'(rnd_w));
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    unique case (state_r)
      tkf_pkg::S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = tkf_pkg::S_MUL_A;
          op_nxt    = tkf_pkg::OP_ANGLE_PRED;
        end
      end
      tkf_pkg::S_MUL_A: state_nxt = tkf_pkg::S_MUL_B;
      tkf_pkg::S_MUL_B: begin
        if (op_r == tkf_pkg::OP_BB_PRED) begin
          state_nxt = tkf_pkg::S_WAIT_CORDIC;
        end else if (op_r == tkf_pkg::OP_BIAS_CORR) begin
          state_nxt = tkf_pkg::S_OUT;
        end else begin
          state_nxt = tkf_pkg::S_MUL_A;
          op_nxt    = tkf_pkg::mul_op_t'(op_r + 4'd1);
        end
      end
      tkf_pkg::S_WAIT_CORDIC: begin
        if (cordic_res.done) state_nxt = tkf_pkg::S_DIV_START;
      end
      tkf_pkg::S_DIV_START: state_nxt = tkf_pkg::S_DIV_WAIT;
      tkf_pkg::S_DIV_WAIT: begin
        if (div_res.done) begin
          if (div_sel_r) begin
            state_nxt = tkf_pkg::S_MUL_A;
            op_nxt    = tkf_pkg::OP_BA_CORR;
          end else begin
            state_nxt = tkf_pkg::S_DIV_START;
          end
        end
      end
      tkf_pkg::S_OUT: begin
        if (!out_valid_r || out_tready) state_nxt = tkf_pkg::S_IDLE;
      end
      default: state_nxt = tkf_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tkf_pkg::S_IDLE;
      op_r        <= tkf_pkg::OP_ANGLE_PRED;
      out_valid_r <= 1'b0;
      div_sel_r   <= 1'b0;
      ts_r        <= tkf_pkg::TIME_STEP_RST;
      apn_r       <= tkf_pkg::APN_RST;
      bpn_r       <= tkf_pkg::BPN_RST;
      mn_r        <= tkf_pkg::MN_RST;
      angle_r     <= 32'sd0;
      bias_r      <= 32'sd0;
      caa_r       <= tkf_pkg::COV_ONE;
      cab_r       <= 32'sd0;
      cba_r       <= 32'sd0;
      cbb_r       <= tkf_pkg::COV_ONE;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;

      if (cfg_valid) begin
        unique case (tkf_pkg::cfg_reg_t'(cfg_index))
          tkf_pkg::REG_TIME_STEP:   ts_r  <= cfg_data[15:0];
          tkf_pkg::REG_ANGLE_NOISE: apn_r <= cfg_data[30:0];
          tkf_pkg::REG_BIAS_NOISE:  bpn_r <= cfg_data[30:0];
          tkf_pkg::REG_MEAS_NOISE:  mn_r  <= cfg_data[30:0];
          default: ;
        endcase
      end

      if (accept) begin
        q_r <= tkf_pkg::sub_sat($signed(in_tdata[31:0]), bias_r);
      end

      if (state_r == tkf_pkg::S_MUL_A) begin
        prod_r <= opa * opb;
      end

      if (state_r == tkf_pkg::S_MUL_B) begin
        case (op_r)
          tkf_pkg::OP_ANGLE_PRED: angle_r <= tkf_pkg::add_sat(angle_r, r);
          tkf_pkg::OP_AA_PRED:    caa_r   <= tkf_pkg::add_sat(caa_r, r);
          tkf_pkg::OP_AB_PRED: begin
            cab_r <= tkf_pkg::add_sat(cab_r, r);
            cba_r <= tkf_pkg::add_sat(cba_r, r);
          end
          tkf_pkg::OP_BB_PRED:    cbb_r   <= tkf_pkg::add_sat(cbb_r, r);
          tkf_pkg::OP_BA_CORR:    cba_r   <= tkf_pkg::sub_sat(cba_r, r);
          tkf_pkg::OP_BB_CORR:    cbb_r   <= tkf_pkg::sub_sat(cbb_r, r);
          tkf_pkg::OP_AA_CORR:    caa_r   <= tkf_pkg::sub_sat(caa_r, r);
          tkf_pkg::OP_AB_CORR:    cab_r   <= tkf_pkg::sub_sat(cab_r, r);
          tkf_pkg::OP_ANGLE_CORR: angle_r <= tkf_pkg::add_sat(angle_r, r);
          tkf_pkg::OP_BIAS_CORR:  bias_r  <= tkf_pkg::add_sat(bias_r, r);
          default: ;
        endcase
      end

      if (state_r == tkf_pkg::S_WAIT_CORDIC && cordic_res.done) begin
        err_r     <= tkf_pkg::sub_sat(cordic_res.value, angle_r);
        e_r       <= $signed({2'b0, mn_r}) + 33'(caa_r);
        div_sel_r <= 1'b0;
      end

      if (state_r == tkf_pkg::S_DIV_WAIT && div_res.done) begin
        if (div_sel_r) begin
          k1_r <= div_res.value;
        end else begin
          k0_r      <= div_res.value;
          div_sel_r <= 1'b1;
        end
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
        out_angle_r <= angle_r;
        out_rate_r  <= q_r;
        out_bias_r  <= bias_r;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_bias_r, out_rate_r, out_angle_r};

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("input taken again right after a word was accepted");

  a_cordic_before_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tkf_pkg::S_OUT) |-> cordic_res.done)
    else $error("result formed before the measured angle was ready");

  a_mul_two_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tkf_pkg::S_MUL_B) |-> ($past(state_r) == tkf_pkg::S_MUL_A))
    else $error("multiply result used without a product register load");

endmodule

`default_nettype wire

@@ hdl/tkf_cordic.sv @@
// ----------------------------------------------------------------------------
// tkf_cordic
// Vectoring CORDIC, one iteration per cycle: 57.295*atan2(-ax, az) in Q16.16.
// ----------------------------------------------------------------------------
`default_nettype none

module tkf_cordic #(
  parameter int STEPS = tkf_pkg::CORDIC_STEPS_DEF
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  input  wire signed [15:0] accel_x,
  input  wire signed [15:0] accel_z,
  output tkf_pkg::unit_res_t res
);

  localparam int CW = $clog2(STEPS);
  localparam logic [CW-1:0] LAST = CW'(STEPS - 1);

  logic                 busy_r;
  logic                 done_r;
  logic [CW-1:0]        cnt_r;
  logic signed [35:0]   x_r;
  logic signed [35:0]   y_r;
  logic signed [39:0]   z_r;
  logic                 zero_r;
  logic                 zneg_r;

  logic signed [16:0]   nax;
  logic signed [35:0]   x_init;
  logic signed [35:0]   y_init;
  logic signed [39:0]   t0;
  logic signed [35:0]   dx;
  logic signed [35:0]   dy;
  logic signed [39:0]   tab;
  logic signed [39:0]   z_sel;
  logic signed [39:0]   z_rnd;

  always_comb begin
    nax    = -(17'(accel_x));
    x_init = $signed({{4{accel_z[15]}}, accel_z, 16'b0});
    y_init = $signed({{3{nax[16]}}, nax, 16'b0});
    t0     = $signed(tkf_pkg::atan_entry(5'd0));
    dx     = y_r >>> cnt_r;
    dy     = x_r >>> cnt_r;
    tab    = $signed(tkf_pkg::atan_entry(5'(cnt_r)));
    if (zero_r) begin
      z_sel = zneg_r ? -(t0 <<< 2) : 40'sd0;
    end else begin
      z_sel = z_r;
    end
    z_rnd = (z_sel + 40'sd8192) >>> 14;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
      zero_r <= (accel_x == 16'sd0);
      zneg_r <= accel_z[15];
      if (accel_z[15]) begin
        if (accel_x[15]) begin
          x_r <= y_init;
          y_r <= -x_init;
          z_r <= t0 <<< 1;
        end else begin
          x_r <= -y_init;
          y_r <= x_init;
          z_r <= -(t0 <<< 1);
        end
      end else begin
        x_r <= x_init;
        y_r <= y_init;
        z_r <= 40'sd0;
      end
    end else if (busy_r) begin
      if (y_r > 36'sd0) begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + tab;
      end else begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - tab;
      end
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign res.done  = done_r;
  assign res.value = tkf_pkg::sat32(66'(z_rnd));

endmodule

`default_nettype wire

@@ hdl/tkf_div.sv @@
// ----------------------------------------------------------------------------
// tkf_div
// Restoring divider, one quotient bit per cycle: round(num*2^16/den),
// ties away from zero, saturated to 32 bits; zero divisor gives zero.
// ----------------------------------------------------------------------------
`default_nettype none

module tkf_div (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  input  wire signed [31:0] num,
  input  wire signed [32:0] den,
  output tkf_pkg::unit_res_t res
);

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [31:0] rem_r;
  logic [31:0] low_r;
  logic [31:0] d_r;
  logic [31:0] quo_r;
  logic        neg_r;
  logic        big_r;
  logic        zero_r;

  logic [32:0] nabs;
  logic [32:0] dabs;
  logic [48:0] nn;
  logic        big;
  logic        zero;
  logic [32:0] rem2;
  logic        qbit;
  logic signed [31:0] value;

  always_comb begin
    nabs = num[31] ? -(33'(num)) : 33'(num);
    dabs = den[32] ? -den : den;
    nn   = 49'({nabs[31:0], 16'b0}) + 49'(dabs[31:1]);
    zero = (den == 33'sd0);
    big  = (32'(nn[48:32]) >= dabs[31:0]);
    rem2 = {rem_r, low_r[31]};
    qbit = (rem2 >= {1'b0, d_r});
    if (zero_r) begin
      value = 32'sd0;
    end else if (big_r) begin
      value = neg_r ? 32'sh80000000 : 32'sh7fffffff;
    end else if (neg_r) begin
      value = (quo_r > 32'h80000000) ? 32'sh80000000 : $signed(-quo_r);
    end else begin
      value = quo_r[31] ? 32'sh7fffffff : $signed(quo_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= !(zero || big);
      done_r <= zero || big;
      cnt_r  <= '0;
      rem_r  <= 32'(nn[48:32]);
      low_r  <= nn[31:0];
      d_r    <= dabs[31:0];
      quo_r  <= '0;
      neg_r  <= num[31] ^ den[32];
      big_r  <= big;
      zero_r <= zero;
    end else if (busy_r) begin
      rem_r <= qbit ? 32'(rem2 - {1'b0, d_r}) : rem2[31:0];
      low_r <= {low_r[30:0], 1'b0};
      quo_r <= {quo_r[30:0], qbit};
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == 5'd31) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign res.done  = done_r;
  assign res.value = value;

endmodule

`default_nettype wire
